// ----- sv/kbv_pkg.sv -----
// ----------------------------------------------------------------------------
// kbv_pkg
// Shared types for the knapsack best-value block: controller states and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package kbv_pkg;

   typedef enum logic [2:0] {
      ST_CLR_START,
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_CAP_RD,
      ST_CAP_WAIT
   } state_type;

   typedef struct packed {
      logic load_item;
      logic walk_step;
      logic clear_init;
      logic clear_step;
      logic cap_read;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic walk_last;
      logic clear_last;
      logic item_last;
   } status_type;

endpackage

// ----- sv/knapsack_best_value.sv -----
// ----------------------------------------------------------------------------
// knapsack_best_value
// 0/1 knapsack best total value over a one-dimensional table held in RAM.
// ----------------------------------------------------------------------------
// Item: after accept, the table walk updates one entry per cycle from the
//   capacity down to the weight; no walk when the weight exceeds the capacity.
// Last item: the entry at the capacity is read into the result register once the
//   result slot is free, then a clearing pass zeroes the table, one entry a cycle.
// Reset: synchronous; the same clearing pass runs after reset, req_tready low.
// ----------------------------------------------------------------------------
module knapsack_best_value #(
   parameter int MAX_CAPACITY = 1024,
   parameter int VALUE_WIDTH  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [9:0]  csr_data,    // capacity
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // item_weight[9:0], item_value[25:10], zeros
   input  logic        req_tlast,   // last_item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // best_value
);
   import kbv_pkg::*;

   cmd_type    cmd;
   status_type sts;

   assign csr_ready = 1'b1;

   kbv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   kbv_datapath #(
      .MAX_CAPACITY (MAX_CAPACITY),
      .VALUE_WIDTH  (VALUE_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .csr_we      (csr_valid),
      .csr_data    (csr_data),
      .item_weight (req_tdata[9:0]),
      .item_value  (req_tdata[25:10]),
      .last_item   (req_tlast),
      .best_value  (rsp_tdata)
   );

endmodule

// ----- sv/kbv_ram.sv -----
// ----------------------------------------------------------------------------
// kbv_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module kbv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   output logic [WIDTH-1:0]         rdata_a,
   input  logic                     re_b,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re_a) begin
         rdata_a <= mem[raddr_a];
      end
      if (re_b) begin
         rdata_b <= mem[raddr_b];
      end
   end

endmodule

// ----- sv/kbv_datapath.sv -----
// ----------------------------------------------------------------------------
// kbv_datapath
// Table memory, walk and clear address counter, saturating add-and-max update,
// capacity register and result register.
// ----------------------------------------------------------------------------
module kbv_datapath #(
   parameter int MAX_CAPACITY = 1024,
   parameter int VALUE_WIDTH  = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  kbv_pkg::cmd_type    cmd,
   output kbv_pkg::status_type sts,
   input  logic                csr_we,
   input  logic [9:0]          csr_data,
   input  logic [9:0]          item_weight,
   input  logic [15:0]         item_value,
   input  logic                last_item,
   output logic [31:0]         best_value
);
   import kbv_pkg::*;

   localparam int AW = $clog2(MAX_CAPACITY);
   localparam int CW = (AW > 10) ? AW : 10;
   localparam int XW = (VALUE_WIDTH > 16) ? VALUE_WIDTH : 16;
   localparam logic [VALUE_WIDTH-1:0] VMAX = {VALUE_WIDTH{1'b1}};
   localparam logic [AW-1:0] TOP_ADDR = AW'(MAX_CAPACITY - 1);

   logic [9:0]             capacity_ff;
   logic [9:0]             weight_ff;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                   last_ff;
   logic [AW-1:0]          addr_ff, addr_in;
   logic [AW-1:0]          wr_addr_ff;
   logic                   wr_pend_ff;
   logic [31:0]            best_ff, best_in;

   logic [CW-1:0]          cap_x, weight_x;
   logic [AW-1:0]          cap_eff;
   logic [XW-1:0]          value_x;
   logic [VALUE_WIDTH-1:0] rd_a, rd_b, cand, new_val;
   logic [VALUE_WIDTH:0]   sum;
   logic [63:0]            rd_a64;
   logic                   ram_we;
   logic [AW-1:0]          ram_waddr;
   logic [VALUE_WIDTH-1:0] ram_wdata;

   // clamp capacity to the table and value to the value width
   always_comb begin
      cap_x    = CW'(capacity_ff);
      weight_x = CW'(weight_ff);
      cap_eff  = (cap_x > CW'(MAX_CAPACITY - 1)) ? TOP_ADDR : cap_x[AW-1:0];
      value_x  = XW'(item_value);
      value_in = (value_x > XW'(VMAX)) ? VMAX : value_x[VALUE_WIDTH-1:0];
   end

   always_comb begin
      sts.skip       = weight_x > CW'(cap_eff);
      sts.walk_last  = CW'(addr_ff) == weight_x;
      sts.clear_last = addr_ff == '0;
      sts.item_last  = last_ff;
   end

   // saturating sum, then keep the larger
   always_comb begin
      sum     = {1'b0, rd_b} + {1'b0, value_ff};
      cand    = sum[VALUE_WIDTH] ? VMAX : sum[VALUE_WIDTH-1:0];
      new_val = (cand > rd_a) ? cand : rd_a;
      rd_a64  = 64'(rd_a);
      if (cap_eff == '0) begin
         best_in = '0;
      end else if (rd_a64 > 64'h0000_0000_FFFF_FFFF) begin
         best_in = 32'hFFFF_FFFF;
      end else begin
         best_in = rd_a64[31:0];
      end
   end

   always_comb begin
      addr_in = addr_ff;
      if (cmd.load_item) begin
         addr_in = cap_eff;
      end else if (cmd.clear_init) begin
         addr_in = TOP_ADDR;
      end else if (cmd.walk_step || cmd.clear_step) begin
         addr_in = addr_ff - 1'b1;
      end
   end

   always_comb begin
      ram_we    = cmd.clear_step || wr_pend_ff;
      ram_waddr = cmd.clear_step ? addr_ff : wr_addr_ff;
      ram_wdata = cmd.clear_step ? '0 : new_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= '0;
         wr_pend_ff  <= 1'b0;
         addr_ff     <= '0;
      end else begin
         if (csr_we) begin
            capacity_ff <= csr_data;
         end
         wr_pend_ff <= cmd.walk_step;
         addr_ff    <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         weight_ff <= item_weight;
         value_ff  <= value_in;
         last_ff   <= last_item;
      end
      wr_addr_ff <= addr_ff;
      if (cmd.out_load) begin
         best_ff <= best_in;
      end
   end

   kbv_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (MAX_CAPACITY)
   ) u_table (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .re_a    (cmd.walk_step || cmd.cap_read),
      .raddr_a (cmd.cap_read ? cap_eff : addr_ff),
      .rdata_a (rd_a),
      .re_b    (cmd.walk_step),
      .raddr_b (addr_ff - weight_x[AW-1:0]),
      .rdata_b (rd_b)
   );

   assign best_value = best_ff;

endmodule

// ----- sv/kbv_ctrl.sv -----
// ----------------------------------------------------------------------------
// kbv_ctrl
// Sequencer: accepts items, walks the table, reads the answer, clears the
// table, and holds the result valid flag.
// ----------------------------------------------------------------------------
module kbv_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output kbv_pkg::cmd_type    cmd,
   input  kbv_pkg::status_type sts
);
   import kbv_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLR_START: state_in = ST_CLEAR;
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (sts.skip) begin
               state_in = sts.item_last ? ST_CAP_RD : ST_IDLE;
            end else if (sts.walk_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:    state_in = sts.item_last ? ST_CAP_RD : ST_IDLE;
         ST_CAP_RD:   state_in = ST_CAP_WAIT;
         ST_CAP_WAIT: begin
            if (slot_free) state_in = ST_CLR_START;
         end
         default:     state_in = ST_CLR_START;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLR_START: cmd.clear_init = 1'b1;
         ST_CLEAR:     cmd.clear_step = 1'b1;
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.load_item = req_tvalid;
         end
         ST_WALK:      cmd.walk_step = !sts.skip;
         ST_DRAIN:     cmd = '0;
         ST_CAP_RD:    cmd.cap_read = 1'b1;
         ST_CAP_WAIT:  cmd.out_load = slot_free;
         default:      cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register loaded while a result is pending");

   a_walk_clear_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.walk_step && cmd.clear_step))
      else $error("walk and clear write the table in one cycle");

   a_clear_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && sts.clear_last) |=> (state_ff == ST_IDLE))
      else $error("clear pass did not return to idle");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK || state_ff == ST_CLEAR) |-> !cmd.load_item)
      else $error("item accepted while the table is busy");

endmodule

// ----- test/knapsack_best_value_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knapsack_best_value_tb
// Self-checking bench for the knapsack best-value block. A short table of
// directed items is followed by random item sets over a range of capacities.
// Every accepted item is folded into a local copy of the value table, and
// each result transfer is compared with the oldest predicted best value.
// The item side is driven in bursts with gaps, and the result side is stalled
// on its own pattern, with one long hold-off that backs up the input.
// ----------------------------------------------------------------------------
module knapsack_best_value_tb;

   localparam int TABLE_DEPTH   = 1024;
   localparam int SETTLE_CYCLES = 2200;   // longest walk + read + clearing pass
   localparam int LONG_HOLD     = 3000;
   localparam int RANDOM_ITEMS  = 540;
   localparam int NUM_ROWS      = 21;
   localparam int MAX_REPORTS   = 10;

   typedef enum int {
      RX_OPEN,
      RX_COIN,
      RX_SPARSE,
      RX_SQUARE
   } rx_mode_type;

   typedef struct packed {
      logic        cfg_en;
      logic [9:0]  cfg_cap;
      logic [9:0]  weight;
      logic [15:0] value;
      logic        last;
      logic        typed;
      logic [31:0] typed_best;
   } item_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [9:0]  csr_data   = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   // local copy of the block state
   logic [31:0] best_tbl [0:TABLE_DEPTH-1];
   logic [9:0]  cap_model = '0;
   logic [31:0] best_value_q [$];

   item_row_type rows [0:NUM_ROWS-1];
   int          row_count      = 0;

   int          fail_count     = 0;
   int          results_ok     = 0;
   int          items_sent     = 0;
   int          sets_closed    = 0;
   int          cap_writes     = 0;
   int          widest_cap     = 0;
   int          burst_left     = 0;

   int          hold_requests  = 0;
   int          hold_served    = 0;
   int          hold_left      = 0;
   rx_mode_type rx_mode        = RX_OPEN;
   int          rx_mode_left   = 0;
   logic [7:0]  rx_tick        = '0;

   knapsack_best_value u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("Timeout with %0d results still outstanding", best_value_q.size());
      $display("Regression FAIL");
      $finish;
   end

   // Fold one item into the table; on the last item of a set return the
   // best value at the capacity and clear the table.
   task automatic fold_item(input logic [9:0] weight, input logic [15:0] value,
                            input logic last, output logic produced,
                            output logic [31:0] best);
      int          w;
      logic [32:0] sum;
      logic [31:0] cand;
      if (weight <= cap_model) begin
         for (w = int'(cap_model); w >= int'(weight); w--) begin
            sum  = {1'b0, best_tbl[w - int'(weight)]} + 33'(value);
            cand = sum[32] ? '1 : sum[31:0];
            if (cand > best_tbl[w]) best_tbl[w] = cand;
         end
      end
      produced = last;
      best     = (cap_model == 0) ? '0 : best_tbl[cap_model];
      if (last) begin
         foreach (best_tbl[i]) best_tbl[i] = '0;
      end
   endtask

   task automatic add_row(input logic cfg_en, input logic [9:0] cfg_cap,
                          input logic [9:0] weight, input logic [15:0] value,
                          input logic last, input logic typed,
                          input logic [31:0] typed_best);
      rows[row_count] = '{cfg_en, cfg_cap, weight, value, last, typed, typed_best};
      row_count++;
   endtask

   // Offer one item, hold until the transfer, then pace the next one.
   task automatic send_item(input logic [9:0] weight, input logic [15:0] value,
                            input logic last, input logic typed,
                            input logic [31:0] typed_best);
      logic        produced;
      logic [31:0] best;
      int          gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, value, weight};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      fold_item(weight, value, last, produced, best);
      if (produced) begin
         best_value_q = {best_value_q, (typed ? typed_best : best)};
         sets_closed++;
      end
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 8);
      end
   endtask

   // Drop valid and wait until every result is in and the block has gone quiet.
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (best_value_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [9:0] cap);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      do @(posedge clock); while (!csr_ready);
      cap_model = cap;
      csr_valid <= 1'b0;
      cap_writes++;
      if (int'(cap) > widest_cap) widest_cap = int'(cap);
   endtask

   // Result side: long hold-off on request, otherwise a changing stall pattern.
   always @(posedge clock) begin
      rx_tick <= rx_tick + 8'd1;
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= LONG_HOLD;
         rsp_tready  <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      <= rx_mode_type'($urandom_range(0, 3));
            rx_mode_left <= $urandom_range(50, 300);
         end else begin
            rx_mode_left <= rx_mode_left - 1;
         end
         case (rx_mode)
            RX_OPEN:   rsp_tready <= 1'b1;
            RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:   rsp_tready <= rx_tick[3];
         endcase
      end
   end

   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (best_value_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("Unexpected result transfer: best_value %h", rsp_tdata);
         end else begin
            want = best_value_q.pop_front();
            if (rsp_tdata !== want) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("best_value mismatch: expected %h, got %h", want, rsp_tdata);
            end else begin
               results_ok++;
            end
         end
      end
   end

   initial begin
      int          k;
      int          r;
      int          phase;
      int          n_items;
      int          set_left;
      int          random_items;
      logic [9:0]  cap;
      logic [9:0]  weight;
      logic [15:0] value;
      logic        last;

      foreach (best_tbl[i]) best_tbl[i] = '0;

      // capacity is still at its reset value of zero for the first row
      add_row(1'b0, 10'd0,    10'd0,    16'hFFFF, 1'b1, 1'b1, 32'd0);
      add_row(1'b1, 10'd1023, 10'd1023, 16'hFFFF, 1'b1, 1'b1, 32'd65535);
      // zero weight gains its value at every entry, once per item
      add_row(1'b0, 10'd0,    10'd0,    16'hFFFF, 1'b0, 1'b0, 32'd0);
      add_row(1'b0, 10'd0,    10'd0,    16'd1,    1'b1, 1'b1, 32'd65536);
      // heavier than the capacity: never taken
      add_row(1'b1, 10'd10,   10'd11,   16'd100,  1'b1, 1'b1, 32'd0);
      add_row(1'b0, 10'd0,    10'd3,    16'd5,    1'b0, 1'b0, 32'd0);
      add_row(1'b0, 10'd0,    10'd4,    16'd6,    1'b0, 1'b0, 32'd0);
      add_row(1'b0, 10'd0,    10'd5,    16'd8,    1'b1, 1'b0, 32'd0);
      add_row(1'b0, 10'd0,    10'd10,   16'd1000, 1'b0, 1'b0, 32'd0);
      add_row(1'b0, 10'd0,    10'd10,   16'd999,  1'b1, 1'b1, 32'd1000);
      add_row(1'b1, 10'd1,    10'd1,    16'hFFFF, 1'b1, 1'b1, 32'd65535);
      add_row(1'b0, 10'd0,    10'd0,    16'd0,    1'b1, 1'b1, 32'd0);
      // capacity raised in the middle of a set
      add_row(1'b1, 10'd5,    10'd2,    16'd3,    1'b0, 1'b0, 32'd0);
      add_row(1'b0, 10'd0,    10'd8,    16'd50,   1'b0, 1'b0, 32'd0);
      add_row(1'b1, 10'd20,   10'd8,    16'd7,    1'b0, 1'b0, 32'd0);
      add_row(1'b0, 10'd0,    10'd12,   16'd9,    1'b1, 1'b0, 32'd0);
      add_row(1'b1, 10'd0,    10'd0,    16'd12345, 1'b0, 1'b0, 32'd0);
      add_row(1'b0, 10'd0,    10'd1,    16'd7,    1'b1, 1'b1, 32'd0);
      add_row(1'b1, 10'd1023, 10'd512,  16'hAAAA, 1'b0, 1'b0, 32'd0);
      add_row(1'b0, 10'd0,    10'd511,  16'h5555, 1'b0, 1'b0, 32'd0);
      add_row(1'b0, 10'd0,    10'd1,    16'd1,    1'b1, 1'b0, 32'd0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < row_count; k++) begin
         if (rows[k].cfg_en) begin
            settle_block();
            write_capacity(rows[k].cfg_cap);
         end
         send_item(rows[k].weight, rows[k].value, rows[k].last,
                   rows[k].typed, rows[k].typed_best);
      end

      phase        = 0;
      set_left     = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (phase == 0)          cap = 10'd1023;
         else if (phase == 1)     cap = 10'd0;
         else if (phase % 4 == 3) cap = 10'($urandom_range(64, 1023));
         else                     cap = 10'($urandom_range(1, 40));
         settle_block();
         write_capacity(cap);
         // back up the result side once while items keep coming
         if (phase == 2) hold_requests <= hold_requests + 1;
         n_items = (cap >= 64) ? 15 : 60;
         for (k = 0; k < n_items; k++) begin
            if (set_left == 0) set_left = $urandom_range(1, 12);
            last = (set_left == 1);
            // most phases close their last set; the rest carry it over
            if (k == n_items - 1 && $urandom_range(0, 3) != 0) last = 1'b1;
            if (last) set_left = 0;
            else      set_left--;
            r = $urandom_range(0, 9);
            if (r == 0)                 weight = 10'd0;
            else if (r == 1 || r == 2)  weight = 10'($urandom_range(0, 1023));
            else if (r == 3)            weight = cap;
            else                        weight = 10'($urandom_range(0, int'(cap)));
            r = $urandom_range(0, 9);
            if (r == 0)      value = 16'hFFFF;
            else if (r == 1) value = 16'($urandom_range(0, 3));
            else             value = 16'($urandom_range(0, 65535));
            send_item(weight, value, last, 1'b0, 32'd0);
         end
         random_items += n_items;
         phase++;
      end
      settle_block();

      $display("Covered %0d items in %0d closed sets over %0d capacity writes (widest %0d)",
               items_sent, sets_closed, cap_writes, widest_cap);
      $display("Checked %0d best values, %0d failures", results_ok, fail_count);
      if (fail_count == 0 && best_value_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/kbv_pkg.sv
sv/kbv_ram.sv
sv/kbv_datapath.sv
sv/kbv_ctrl.sv
sv/knapsack_best_value.sv
test/knapsack_best_value_tb.sv
